### hw/rtl/dmtp_pkg.sv
package dmtp_pkg;

    localparam int CHAR_W = 8;
    localparam int MAXC_W = 6;
    localparam int POS_W  = 6;
    localparam int INT_W  = 30;
    localparam int FRAC_W = 7;
    localparam int CNT_W  = 2;
    localparam int HUND_W = 38;

    localparam logic [INT_W-1:0]  INT_LIMIT       = INT_W'(100000000);
    localparam logic [MAXC_W-1:0] MAX_CHARS_RESET = MAXC_W'(20);
    localparam logic [POS_W-1:0]  POS_MAX         = '1;
    localparam logic [CNT_W-1:0]  FRAC_DIGITS_MAX = CNT_W'(2);

    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // finished string, handed from the accumulator to the scaler
    typedef struct packed {
        logic              ok;
        logic              neg;
        logic [INT_W-1:0]  int_val;
        logic [FRAC_W-1:0] frac_val;
    } snap_t;

endpackage

### hw/rtl/dmtp_if.sv
interface dmtp_char_if;
    import dmtp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dmtp_res_if;
    import dmtp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     valid_res;
    logic signed [HUND_W-1:0] hundredths;

    modport source (output valid, output valid_res, output hundredths, input ready);
    modport sink   (input valid, input valid_res, input hundredths, output ready);
endinterface

### hw/rtl/dmtp_accum.sv
module dmtp_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dmtp_pkg::MAXC_W-1:0] cfg_wdata,
    dmtp_char_if.sink                   char_in,
    output dmtp_pkg::snap_t             snap,
    output logic                        snap_valid,
    input  logic                        snap_ready
);
    import dmtp_pkg::*;

    logic [MAXC_W-1:0] max_chars_reg;
    logic [INT_W-1:0]  int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              dot_reg, dot_next;
    logic              digit_reg, digit_next;
    logic              neg_reg, neg_next;
    logic              failed_reg, failed_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    snap_t             snap_reg, snap_next;
    logic              snap_valid_reg, snap_valid_next;

    logic              in_xfer;
    logic              fin_xfer;
    logic [POS_W:0]    len;
    logic [CHAR_W-1:0] c;
    logic [3:0]        d;

    assign char_in.ready = !snap_valid_reg || snap_ready;
    assign in_xfer  = char_in.valid && char_in.ready;
    assign fin_xfer = in_xfer && char_in.last_char;
    assign c        = char_in.char_code;
    assign d        = 4'(c - CH_ZERO);
    assign len      = {1'b0, pos_reg} + (POS_W+1)'(1);

    always_comb
    begin
        int_next    = int_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        dot_next    = dot_reg;
        digit_next  = digit_reg;
        neg_next    = neg_reg;
        pos_next    = (len > {1'b0, POS_MAX}) ? POS_MAX : len[POS_W-1:0];
        failed_next = failed_reg || (len > (POS_W+1)'(max_chars_reg));
        if (!failed_next)
        begin
            if ((pos_reg == '0) && (c == CH_PLUS || c == CH_MINUS))
            begin
                neg_next = (c == CH_MINUS);
            end
            else if (c == CH_DOT)
            begin
                if (dot_reg)
                    failed_next = 1'b1;
                else
                    dot_next = 1'b1;
            end
            else if (!(c inside {[CH_ZERO:CH_NINE]}))
            begin
                failed_next = 1'b1;
            end
            else
            begin
                digit_next = 1'b1;
                if (!dot_reg)
                begin
                    if (int_reg > INT_LIMIT)
                        failed_next = 1'b1;
                    else
                        int_next = (int_reg << 3) + (int_reg << 1) + INT_W'(d);
                end
                else
                begin
                    if (cnt_reg >= FRAC_DIGITS_MAX)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next  = cnt_reg + CNT_W'(1);
                        frac_next = (frac_reg << 3) + (frac_reg << 1) + FRAC_W'(d);
                    end
                end
            end
        end
    end

    always_comb
    begin
        snap_next.ok       = !failed_next && digit_next;
        snap_next.neg      = neg_next;
        snap_next.int_val  = int_next;
        // a lone fraction digit counts tenths
        snap_next.frac_val = (cnt_next == CNT_W'(1))
                           ? FRAC_W'((frac_next << 3) + (frac_next << 1))
                           : frac_next;
        if (fin_xfer)
            snap_valid_next = 1'b1;
        else if (snap_ready)
            snap_valid_next = 1'b0;
        else
            snap_valid_next = snap_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg  <= MAX_CHARS_RESET;
            int_reg        <= '0;
            frac_reg       <= '0;
            cnt_reg        <= '0;
            dot_reg        <= 1'b0;
            digit_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            failed_reg     <= 1'b0;
            pos_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_chars_reg <= cfg_wdata;
            snap_valid_reg <= snap_valid_next;
            if (fin_xfer)
            begin
                // drop the string state once its result is captured
                int_reg    <= '0;
                frac_reg   <= '0;
                cnt_reg    <= '0;
                dot_reg    <= 1'b0;
                digit_reg  <= 1'b0;
                neg_reg    <= 1'b0;
                failed_reg <= 1'b0;
                pos_reg    <= '0;
            end
            else if (in_xfer)
            begin
                int_reg    <= int_next;
                frac_reg   <= frac_next;
                cnt_reg    <= cnt_next;
                dot_reg    <= dot_next;
                digit_reg  <= digit_next;
                neg_reg    <= neg_next;
                failed_reg <= failed_next;
                pos_reg    <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_xfer)
            snap_reg <= snap_next;
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;

    a_fin_loads_snap: assert property (@(posedge clk) disable iff (!rst_n)
        fin_xfer |=> snap_valid_reg)
        else $error("final character did not produce a pending result");

    a_fin_clears_string: assert property (@(posedge clk) disable iff (!rst_n)
        fin_xfer |=> (pos_reg == '0) && !failed_reg && !dot_reg && !digit_reg)
        else $error("string state not cleared after final character");

    a_snap_holds: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg && !snap_ready |=> snap_valid_reg && $stable(snap_reg))
        else $error("pending result changed while stalled");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FRAC_DIGITS_MAX)
        else $error("fraction digit count out of range");
endmodule

### hw/rtl/dmtp_scale.sv
module dmtp_scale (
    input  logic            clk,
    input  logic            rst_n,
    input  dmtp_pkg::snap_t snap,
    input  logic            snap_valid,
    output logic            snap_ready,
    dmtp_res_if.source      res_out
);
    import dmtp_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic              ok_reg;
    logic [HUND_W-1:0] hund_reg, hund_next;
    logic [HUND_W-1:0] iw;
    logic [HUND_W-1:0] mag;
    logic              load;

    assign snap_ready = !out_valid_reg || res_out.ready;
    assign load       = snap_valid && snap_ready;

    always_comb
    begin
        iw  = HUND_W'(snap.int_val);
        // int * 100 = int * 64 + int * 32 + int * 4
        mag = (iw << 6) + (iw << 5) + (iw << 2) + HUND_W'(snap.frac_val);
        if (!snap.ok)
            hund_next = '0;
        else if (snap.neg)
            hund_next = '0 - mag;
        else
            hund_next = mag;
        if (load)
            out_valid_next = 1'b1;
        else if (res_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg   <= snap.ok;
            hund_reg <= hund_next;
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.valid_res  = ok_reg;
    assign res_out.hundredths = $signed(hund_reg);

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_reg |-> hund_reg == '0)
        else $error("invalid result carries a nonzero amount");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg && ok_reg == $past(snap.ok))
        else $error("result register missed a transfer");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_out.ready |=> out_valid_reg && $stable(hund_reg) && $stable(ok_reg))
        else $error("offered result changed while stalled");
endmodule

### hw/rtl/decimal_money_text_parser.sv
// The result of a string passes the string snapshot register once its final character
// is transferred, then the scaling output register, before it is offered.
// Throughput: one character per cycle unless stalled; the multiply-by-ten accumulate
// completes in the cycle of each transfer, the x100 scaling in the following stage.
// Reset (rst_n low, asynchronous): string state and pending results clear, max_chars = 20.
module decimal_money_text_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dmtp_pkg::MAXC_W-1:0] cfg_wdata,
    dmtp_char_if.sink                   char_in,
    dmtp_res_if.source                  res_out
);
    import dmtp_pkg::*;

    snap_t snap;
    logic  snap_valid;
    logic  snap_ready;

    dmtp_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .char_in    (char_in),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready)
    );

    dmtp_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .res_out    (res_out)
    );
endmodule

### tb/testbench.sv
module testbench;
    import dmtp_pkg::*;

    typedef struct {
        logic                     ok;
        logic signed [HUND_W-1:0] val;
    } amount_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              typed;
        logic              ok;
        logic [HUND_W-1:0] val;
    } dir_row_t;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 6;

    // short strings first, then the error cases; a typed result is checked as written
    localparam dir_row_t DIRECTED [24] = '{
        '{"7", 1'b1, 1'b1, 1'b1, 38'd700},
        '{"-", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"0", 1'b0, 1'b0, 1'b0, 38'd0},
        '{".", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"5", 1'b1, 1'b0, 1'b0, 38'd0},
        '{"+", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"1", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"2", 1'b0, 1'b0, 1'b0, 38'd0},
        '{".", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"3", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"4", 1'b1, 1'b1, 1'b1, 38'd1234},
        '{"1", 1'b0, 1'b0, 1'b0, 38'd0},
        '{".", 1'b0, 1'b0, 1'b0, 38'd0},
        '{".", 1'b1, 1'b1, 1'b0, 38'd0},
        '{"5", 1'b0, 1'b0, 1'b0, 38'd0},
        '{".", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"1", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"2", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"3", 1'b1, 1'b1, 1'b0, 38'd0},
        '{"-", 1'b1, 1'b1, 1'b0, 38'd0},
        '{"1", 1'b0, 1'b0, 1'b0, 38'd0},
        '{"-", 1'b1, 1'b1, 1'b0, 38'd0},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 38'd0},
        '{".", 1'b1, 1'b1, 1'b0, 38'd0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [MAXC_W-1:0]   cfg_wdata;

    dmtp_char_if char_if ();
    dmtp_res_if  res_if ();

    decimal_money_text_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .char_in   (char_if),
        .res_out   (res_if)
    );

    always #5 clk = ~clk;

    // parser state mirrored from the block
    logic [MAXC_W-1:0] lim_chars;
    logic [POS_W-1:0]  str_len;
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac_part;
    logic [CNT_W-1:0]  frac_len;
    logic              seen_dot;
    logic              seen_digit;
    logic              neg_sign;
    logic              str_bad;

    amount_t amount_q[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      tx_idle_pct = 27;
    int      rx_idle_pct = 27;
    logic    rx_hold_req = 1'b0;

    function automatic void clear_parse();
        str_len    = '0;
        int_part   = '0;
        frac_part  = '0;
        frac_len   = '0;
        seen_dot   = 1'b0;
        seen_digit = 1'b0;
        neg_sign   = 1'b0;
        str_bad    = 1'b0;
    endfunction

    // advance the parse by one character; returns 1 when the string ends
    function automatic logic parse_char(input logic [CHAR_W-1:0] c, input logic last,
                                        output amount_t amt);
        logic [POS_W:0]    len;
        logic              first;
        logic [CHAR_W-1:0] d;
        logic [63:0]       mag;
        len   = {1'b0, str_len} + (POS_W+1)'(1);
        first = (str_len == '0);
        str_len = (len > {1'b0, POS_MAX}) ? POS_MAX : len[POS_W-1:0];
        if (len > {1'b0, lim_chars})
            str_bad = 1'b1;
        if (!str_bad)
        begin
            if (first && (c == CH_PLUS || c == CH_MINUS))
            begin
                neg_sign = (c == CH_MINUS);
            end
            else if (c == CH_DOT)
            begin
                if (seen_dot)
                    str_bad = 1'b1;
                else
                    seen_dot = 1'b1;
            end
            else if (c < CH_ZERO || c > CH_NINE)
            begin
                str_bad = 1'b1;
            end
            else
            begin
                seen_digit = 1'b1;
                d = c - CH_ZERO;
                if (!seen_dot)
                begin
                    if (int_part > INT_LIMIT)
                        str_bad = 1'b1;
                    else
                        int_part = int_part * INT_W'(10) + INT_W'(d);
                end
                else if (frac_len >= FRAC_DIGITS_MAX)
                begin
                    str_bad = 1'b1;
                end
                else
                begin
                    frac_len  = frac_len + CNT_W'(1);
                    frac_part = frac_part * FRAC_W'(10) + FRAC_W'(d);
                end
            end
        end
        if (!last)
            return 1'b0;
        amt.ok  = !str_bad && seen_digit;
        amt.val = '0;
        if (amt.ok)
        begin
            mag = 64'(int_part) * 64'd100
                + ((frac_len == CNT_W'(1)) ? 64'(frac_part) * 64'd10 : 64'(frac_part));
            if (neg_sign)
                mag = -mag;
            amt.val = mag[HUND_W-1:0];
        end
        clear_parse();
        return 1'b1;
    endfunction

    function automatic logic [CHAR_W-1:0] random_digit();
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    task automatic put_char(input logic [CHAR_W-1:0] c, input logic last, input logic typed,
                            input logic t_ok, input logic [HUND_W-1:0] t_val);
        amount_t amt;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        char_if.last_char <= last;
        @(posedge clk);
        while (!char_if.ready) @(posedge clk);
        items_sent++;
        if (parse_char(c, last, amt))
        begin
            if (typed)
            begin
                amt.ok  = t_ok;
                amt.val = $signed(t_val);
            end
            amount_q.push_back(amt);
        end
    endtask

    task automatic send_string();
        logic [CHAR_W-1:0] s[$];
        logic [CHAR_W-1:0] junk;
        int                kind;
        int                n_int;
        kind = $urandom_range(0, 99);
        if (kind < 85)
        begin
            case ($urandom_range(0, 2))
                1: s.push_back(CH_PLUS);
                2: s.push_back(CH_MINUS);
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                // walk right up to the integer limit
                s.push_back(CH_ZERO + 8'd1);
                repeat (7) s.push_back(CH_ZERO);
                s.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 2)) s.push_back(random_digit());
            end
            else
            begin
                n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 11)
                                                    : $urandom_range(0, 4);
                repeat (n_int) s.push_back(random_digit());
            end
            if ($urandom_range(0, 9) < 6)
            begin
                s.push_back(CH_DOT);
                repeat ($urandom_range(0, 2)) s.push_back(random_digit());
            end
            if (kind >= 70)
            begin
                case ($urandom_range(0, 3))
                    0: junk = CH_DOT;
                    1: junk = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                    2: junk = CHAR_W'($urandom_range(0, 255));
                    default: junk = random_digit();
                endcase
                s.insert($urandom_range(0, s.size()), junk);
            end
        end
        else if (kind < 95)
        begin
            repeat ($urandom_range(1, 8)) s.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        else
        begin
            // lengths reach far enough to pass every limit and saturate the length count
            repeat ($urandom_range(20, 70))
                s.push_back(($urandom_range(0, 3) == 0) ? CHAR_W'($urandom_range(0, 255))
                                                        : random_digit());
        end
        if (s.size() == 0)
            s.push_back(random_digit());
        foreach (s[i])
            put_char(s[i], i == s.size() - 1, 1'b0, 1'b0, '0);
    endtask

    task automatic end_phase();
        char_if.valid <= 1'b0;
        while (amount_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [MAXC_W-1:0] limit_val, input int n_items);
        int target;
        cfg_we    <= 1'b1;
        cfg_wdata <= limit_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lim_chars = limit_val;
        target = items_sent + n_items;
        while (items_sent < target) send_string();
        end_phase();
    endtask

    // result side: check each transfer, then pick ready for the next cycle
    initial
    begin
        amount_t want;
        logic    hold_taken;
        hold_taken   = 1'b0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
            begin
                if (amount_q.size() == 0)
                begin
                    $error("result with no expectation waiting: valid_res %0b hundredths %0d",
                           res_if.valid_res, res_if.hundredths);
                    mismatches++;
                end
                else
                begin
                    want = amount_q.pop_front();
                    if (res_if.valid_res !== want.ok)
                    begin
                        $error("valid_res: expected %0b, got %0b", want.ok, res_if.valid_res);
                        mismatches++;
                    end
                    if (res_if.hundredths !== want.val)
                    begin
                        $error("hundredths: expected %0d, got %0d",
                               want.val, res_if.hundredths);
                        mismatches++;
                    end
                end
            end
            if (rx_hold_req && !hold_taken)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_taken = 1'b1;
            end
            else
            begin
                res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        char_if.valid     = 1'b0;
        char_if.char_code = '0;
        char_if.last_char = 1'b0;
        lim_chars         = MAX_CHARS_RESET;
        clear_parse();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            put_char(DIRECTED[i].code, DIRECTED[i].last, DIRECTED[i].typed,
                     DIRECTED[i].ok, DIRECTED[i].val);
        end_phase();

        // reset limit first, no write yet
        begin
            int target;
            target = items_sent + 250;
            while (items_sent < target) send_string();
            end_phase();
        end

        // hold off the result side while characters keep coming
        rx_hold_req = 1'b1;
        run_phase(POS_MAX, 300);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(MAXC_W'(12), 250);
        tx_idle_pct = 27;
        rx_idle_pct = 27;

        run_phase(MAXC_W'(1), 60);
        run_phase(MAXC_W'(0), 40);
        run_phase(MAXC_W'(32), 300);
        run_phase(MAXC_W'($urandom_range(2, 31)), 150);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hw/rtl/dmtp_pkg.sv
hw/rtl/dmtp_if.sv
hw/rtl/dmtp_accum.sv
hw/rtl/dmtp_scale.sv
hw/rtl/decimal_money_text_parser.sv
tb/testbench.sv
